// File: rtl/s2dec_pkg.sv
package s2dec_pkg;

  // Width of the integer on the input stream
  localparam int unsigned IN_W        = 32;
  localparam int unsigned VALUE_BITS  = 32;

  // Result character
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  // Double-dabble bits shifted per pipeline stage
  localparam int unsigned DAB_STEP = 4;

endpackage

// File: rtl/signed_int_to_decimal_ascii_top.sv
// Signed integer to decimal ASCII text.
// Input stream s_axis: one item per integer, tdata[31:0] = value (two's
// complement, the low VALUE_BITS bits are used).
// Output stream m_axis: one item per character, most significant first.
// tdata[5:0] = char_code ('-' or '0'..'9', upper bits zero), tlast marks the
// final character of a number. Zero gives "0", a negative value gives '-'
// and then the digits of its magnitude, with no leading zeros.
// Pipeline: a sign/magnitude stage, ceil(VALUE_BITS/4) double-dabble stages
// that shift up to four bits each, a digit count stage, then a character
// serializer.
// Throughput: one character per cycle while m_axis_tready is high; an item
// has 1 to 11 characters at 32 bits. The serializer sets that rate; the
// pipeline ahead of it takes an item in every cycle while it has room.
// The next item is loaded in the cycle its predecessor's last character
// leaves, so back-to-back numbers stream without gaps.
// Reset clears all valid bits; no characters are pending after reset.
// When m_axis_tready is low the current character holds, the pipeline fills
// up and then s_axis_tready drops; nothing is lost or repeated.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = s2dec_pkg::VALUE_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [s2dec_pkg::IN_W-1:0]         s_axis_tdata,   // [31:0] value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [s2dec_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [5:0] char_code
  output logic                               m_axis_tlast    // last_char
);

  localparam int unsigned VB     = VALUE_BITS;
  localparam int unsigned STEP   = s2dec_pkg::DAB_STEP;
  localparam int unsigned NDIG   = (VB * 31) / 100 + 1;
  localparam int unsigned BCD_W  = NDIG * 4;
  localparam int unsigned WW     = BCD_W + VB;
  localparam int unsigned NDAB   = (VB + STEP - 1) / STEP;
  localparam int unsigned CNT_W  = $clog2(NDIG + 1);
  localparam int unsigned IDX_W  = $clog2(NDIG);
  localparam int unsigned CW     = s2dec_pkg::CHAR_W;
  localparam int unsigned LAST_S = NDAB + 1;

  // Up to STEP double-dabble iterations on {bcd, remaining binary}
  function automatic logic [WW-1:0] dab_steps(input logic [WW-1:0] x,
                                              input int unsigned n);
    logic [WW-1:0] t;
    t = x;
    for (int k = 0; k < STEP; k++) begin
      if (k < n) begin
        for (int d = 0; d < NDIG; d++) begin
          if (t[VB+4*d +: 4] >= 4'd5) begin
            t[VB+4*d +: 4] = t[VB+4*d +: 4] + 4'd3;
          end
        end
        t = t << 1;
      end
    end
    return t;
  endfunction

  logic [LAST_S:0]   vld_q;
  logic [LAST_S+1:0] rdy;
  logic [LAST_S:0]   neg_q;
  logic [WW-1:0]     work_q [NDAB+1];
  logic [WW-1:0]     work_d [NDAB+1];
  logic [BCD_W-1:0]  bcdf_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_d;

  logic [VB-1:0]     val_w;
  logic              val_neg;
  logic [VB-1:0]     val_mag;

  logic              busy_q;
  logic              sgn_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BCD_W-1:0]  bcd_q;
  logic [3:0]        dig [NDIG];
  logic [CW-1:0]     char_code;
  logic              ser_ready;
  logic              out_fire;

  // Bring the input to VALUE_BITS: truncate or zero-extend
  if (VB <= s2dec_pkg::IN_W) begin : g_trunc
    assign val_w = s_axis_tdata[VB-1:0];
  end else begin : g_ext
    assign val_w = {{(VB - s2dec_pkg::IN_W){1'b0}}, s_axis_tdata};
  end

  // The most negative value negates to itself, which as unsigned is 2^(VB-1)
  assign val_neg = val_w[VB-1];
  assign val_mag = val_neg ? ({VB{1'b0}} - val_w) : val_w;

  // A stage advances when it is empty or the next one advances
  assign rdy[LAST_S+1] = ser_ready;
  for (genvar s = 0; s <= LAST_S; s++) begin : g_rdy
    assign rdy[s] = !vld_q[s] || rdy[s+1];
  end

  assign s_axis_tready = rdy[0];

  assign work_d[0] = {{BCD_W{1'b0}}, val_mag};
  for (genvar s = 1; s <= NDAB; s++) begin : g_dab
    localparam int unsigned NSTEP =
      (VB - STEP * (s - 1) >= STEP) ? STEP : VB - STEP * (s - 1);
    assign work_d[s] = dab_steps(work_q[s-1], NSTEP);
  end

  // Count significant digits; zero still has one
  always_comb begin
    cnt_d = CNT_W'(1);
    for (int d = 0; d < NDIG; d++) begin
      if (work_q[NDAB][VB+4*d +: 4] != 4'd0) begin
        cnt_d = CNT_W'(d + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int s = 1; s <= LAST_S; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      work_q[0] <= work_d[0];
      neg_q[0]  <= val_neg;
    end
    for (int s = 1; s <= NDAB; s++) begin
      if (rdy[s]) begin
        work_q[s] <= work_d[s];
        neg_q[s]  <= neg_q[s-1];
      end
    end
    if (rdy[LAST_S]) begin
      bcdf_q        <= work_q[NDAB][WW-1:VB];
      cnt_q         <= cnt_d;
      neg_q[LAST_S] <= neg_q[NDAB];
    end
  end

  // Character serializer
  for (genvar d = 0; d < NDIG; d++) begin : g_dig
    assign dig[d] = bcd_q[4*d +: 4];
  end

  assign char_code     = sgn_q ? s2dec_pkg::ASCII_MINUS
                               : s2dec_pkg::ASCII_ZERO + CW'(dig[idx_q]);
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {{(s2dec_pkg::OUT_TDATA_W - CW){1'b0}}, char_code};
  assign m_axis_tlast  = !sgn_q && (idx_q == '0);
  assign out_fire      = busy_q && m_axis_tready;
  assign ser_ready     = !busy_q || (m_axis_tready && m_axis_tlast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sgn_q  <= 1'b0;
      idx_q  <= '0;
    end else if (ser_ready) begin
      busy_q <= vld_q[LAST_S];
      sgn_q  <= neg_q[LAST_S];
      idx_q  <= IDX_W'(cnt_q - CNT_W'(1));
    end else if (out_fire) begin
      if (sgn_q) begin
        sgn_q <= 1'b0;
      end else begin
        idx_q <= idx_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_ready) begin
      bcd_q <= bcdf_q;
    end
  end

`ifndef ASSERT_OFF
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (char_code == s2dec_pkg::ASCII_MINUS) ||
      ((char_code >= s2dec_pkg::ASCII_ZERO) &&
       (char_code <= s2dec_pkg::ASCII_ZERO + CW'(9))))
    else $error("character code out of range");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sgn_q) |-> !m_axis_tlast)
    else $error("minus sign marked as last character");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST_S] && !ser_ready) |=> vld_q[LAST_S])
    else $error("stalled item dropped from count stage");
`endif

endmodule
